// ===== design/ma_crossover_rsi_signal_defines.svh =====
// Assertion macros shared by the crossover signal block.
// Included by the top level only; no dependencies.
`ifndef MA_CROSSOVER_RSI_SIGNAL_DEFINES_SVH
`define MA_CROSSOVER_RSI_SIGNAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define MCRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcrs assertion failed");

// Next-cycle implication.
`define MCRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcrs assertion failed");

`endif

// ===== design/mcrs_pkg.sv =====
// Shared types and constants of the crossover signal block.
// No dependencies; imported by the top level, front end, divider and engine.
`timescale 1ns / 1ps
package mcrs_pkg;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_S,
    ST_WAIT_S,
    ST_DIV_L,
    ST_WAIT_L,
    ST_DIV_R,
    ST_WAIT_R,
    ST_EMIT
  } engine_state_e;

  localparam logic [2:0] CFG_SHORT_WINDOW    = 3'd0;
  localparam logic [2:0] CFG_LONG_WINDOW     = 3'd1;
  localparam logic [2:0] CFG_STRENGTH_WINDOW = 3'd2;
  localparam logic [2:0] CFG_CROSS_TOLERANCE = 3'd3;
  localparam logic [2:0] CFG_OVERBOUGHT      = 3'd4;
  localparam logic [2:0] CFG_OVERSOLD        = 3'd5;

  localparam logic [8:0]  RST_SHORT_WINDOW    = 9'd5;
  localparam logic [8:0]  RST_LONG_WINDOW     = 9'd20;
  localparam logic [7:0]  RST_STRENGTH_WINDOW = 8'd14;
  localparam logic [19:0] RST_CROSS_TOLERANCE = 20'd100;
  localparam logic [6:0]  RST_OVERBOUGHT      = 7'd70;
  localparam logic [6:0]  RST_OVERSOLD        = 7'd30;

  localparam logic [6:0] STRENGTH_NEUTRAL = 7'd50;
  localparam logic [6:0] STRENGTH_FULL    = 7'd100;
  localparam logic [6:0] PERCENT_SCALE    = 7'd100;

  typedef struct packed {
    logic [19:0] tolerance;
    logic [6:0]  overbought;
    logic [6:0]  oversold;
  } limits_t;

endpackage

// ===== design/ma_crossover_rsi_signal.sv =====
// Moving-average crossover signal with strength-index filter, top level.
// Takes one close price per valid/stall transaction on the input channel and
// returns one result transaction per bar: signal, both averages, strength
// percent and a warm-up flag. Configuration registers are written through a
// plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user should write
// them only while the block is idle, which the block itself does not enforce.
// Input prices go into a two-entry queue; the engine then writes the ring and
// reads it back one entry a cycle over the widest of the short, long and
// strength-plus-one windows, then runs up to three divisions (short, long,
// strength) in turn on the bit-serial divider that they share (SUMW = 32 +
// log2 depth); during warm-up it skips the reads and divisions. A held result
// in the output register does not block the input queue, which stalls only
// when both entries are full. The output holds while out_stall_i. Reset clears
// the queue, bar count, sums, averages and sets registers to their defaults;
// the ring needs no clearing pass since unwritten entries never reach a result.
`timescale 1ns / 1ps
`include "ma_crossover_rsi_signal_defines.svh"
module ma_crossover_rsi_signal #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] close_price_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  trade_signal_o,
  output logic [31:0] short_average_o,
  output logic [31:0] long_average_o,
  output logic [6:0]  strength_percent_o,
  output logic        warming_up_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);
  import mcrs_pkg::*;

  localparam int BW   = $clog2(HISTORY_DEPTH + 2);
  localparam int NW   = (BW > 9) ? BW : 9;
  localparam int SUMW = 32 + $clog2(HISTORY_DEPTH);

  logic [8:0]  sw_q, lw_q;
  logic [7:0]  rw_q;
  logic [19:0] tol_q;
  logic [6:0]  ob_q, os_q;
  logic [NW-1:0] sw_c, lw_c, rw_c, sw_x, lw_x, rw_x;
  limits_t     lim;
  logic        q_valid, q_pop;
  logic [31:0] q_price;
  signal_e     sig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= RST_SHORT_WINDOW;
      lw_q  <= RST_LONG_WINDOW;
      rw_q  <= RST_STRENGTH_WINDOW;
      tol_q <= RST_CROSS_TOLERANCE;
      ob_q  <= RST_OVERBOUGHT;
      os_q  <= RST_OVERSOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_WINDOW:    sw_q  <= cfg_data_i[8:0];
        CFG_LONG_WINDOW:     lw_q  <= cfg_data_i[8:0];
        CFG_STRENGTH_WINDOW: rw_q  <= cfg_data_i[7:0];
        CFG_CROSS_TOLERANCE: tol_q <= cfg_data_i;
        CFG_OVERBOUGHT:      ob_q  <= cfg_data_i[6:0];
        CFG_OVERSOLD:        os_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Zero window acts as one; clip to what the ring holds.
  always_comb begin
    sw_x = NW'(sw_q);
    lw_x = NW'(lw_q);
    rw_x = NW'(rw_q);
    if (sw_x == '0) sw_c = NW'(1);
    else if (sw_x > NW'(HISTORY_DEPTH)) sw_c = NW'(HISTORY_DEPTH);
    else sw_c = sw_x;
    if (lw_x == '0) lw_c = NW'(1);
    else if (lw_x > NW'(HISTORY_DEPTH)) lw_c = NW'(HISTORY_DEPTH);
    else lw_c = lw_x;
    if (rw_x == '0) rw_c = NW'(1);
    else if (rw_x > NW'(HISTORY_DEPTH - 1)) rw_c = NW'(HISTORY_DEPTH - 1);
    else rw_c = rw_x;
    lim.tolerance  = tol_q;
    lim.overbought = ob_q;
    lim.oversold   = os_q;
  end

  mcrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .close_price_i (close_price_i),
    .q_valid_o     (q_valid),
    .q_price_o     (q_price),
    .q_pop_i       (q_pop)
  );

  mcrs_engine #(.DEPTH(HISTORY_DEPTH), .NW(NW), .SUMW(SUMW)) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_price_i          (q_price),
    .q_pop_o            (q_pop),
    .sw_i               (sw_c),
    .lw_i               (lw_c),
    .rw_i               (rw_c),
    .lim_i              (lim),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .trade_signal_o     (sig),
    .short_average_o    (short_average_o),
    .long_average_o     (long_average_o),
    .strength_percent_o (strength_percent_o),
    .warming_up_o       (warming_up_o)
  );

  assign trade_signal_o = sig;

  `MCRS_ASSERT_IMPL(a_warm_hold, clk_i, rst_ni, out_valid_o && warming_up_o, sig == SIG_HOLD)
  `MCRS_ASSERT_IMPL(a_buy_order, clk_i, rst_ni, out_valid_o && (sig == SIG_BUY), short_average_o > long_average_o)
  `MCRS_ASSERT_IMPL(a_sell_order, clk_i, rst_ni, out_valid_o && (sig == SIG_SELL), short_average_o < long_average_o)
  `MCRS_ASSERT_NEXT(a_pct_range, clk_i, rst_ni, out_valid_o, strength_percent_o <= STRENGTH_FULL)
endmodule

// ===== design/mcrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mcrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/mcrs_front.sv =====
// Front end: accepts closing prices and holds them in a two-entry queue.
// Uses mcrs_pkg; drained by the engine.
`timescale 1ns / 1ps
module mcrs_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] close_price_i,
  output logic        q_valid_o,
  output logic [31:0] q_price_o,
  input  logic        q_pop_i
);
  import mcrs_pkg::*;

  logic [31:0] slot_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_price_o  = rptr_q ? slot_q[1] : slot_q[0];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = q_pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (wptr_q) slot_q[1] <= close_price_i;
      else        slot_q[0] <= close_price_i;
    end
  end
endmodule

// ===== design/mcrs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses mcrs_pkg; shared by the engine for averages and strength index.
`timescale 1ns / 1ps
module mcrs_divider #(
  parameter int DW = 47,
  parameter int VW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);
  import mcrs_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [VW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [VW:0]   trial, diff;
  logic          fits;

  always_comb begin
    trial  = {rem_q, dvd_q[DW-1]};
    diff   = trial - {1'b0, dsr_q};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[VW-1:0] : trial[VW-1:0];
      dvd_d = {dvd_q[DW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
endmodule

// ===== design/mcrs_engine.sv =====
// Back end: writes each close to the ring, walks the ring for window sums,
// divides, and decides the signal. Uses mcrs_pkg, mcrs_ram, mcrs_divider.
`timescale 1ns / 1ps
module mcrs_engine #(
  parameter int DEPTH = 256,
  parameter int NW    = 9,
  parameter int SUMW  = 40
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [31:0]              q_price_i,
  output logic                     q_pop_o,
  input  logic [NW-1:0]            sw_i,
  input  logic [NW-1:0]            lw_i,
  input  logic [NW-1:0]            rw_i,
  input  mcrs_pkg::limits_t        lim_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mcrs_pkg::signal_e        trade_signal_o,
  output logic [31:0]              short_average_o,
  output logic [31:0]              long_average_o,
  output logic [6:0]               strength_percent_o,
  output logic                     warming_up_o
);
  import mcrs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = SUMW + 7;

  engine_state_e state_q, state_d;

  logic [AW-1:0]   wpos_q, wpos_d, rd_addr_q, rd_addr_d;
  logic [NW-1:0]   bars_q, bars_d, iss_q, iss_d, ridx_q, ridx_d, bars_n, n_lo, n_total, rw_p1;
  logic            rdv_q, rdv_d, warm_q, warm_d, remnz_q, remnz_d;
  logic [31:0]     prevd_q, prevd_d;
  logic [SUMW-1:0] ssum_q, ssum_d, lsum_q, lsum_d, gain_q, gain_d, loss_q, loss_d;
  logic [31:0]     last_s_q, last_s_d, last_l_q, last_l_d;
  logic [31:0]     prev_s_q, prev_s_d, prev_l_q, prev_l_d;
  logic [6:0]      str_q, str_d;

  logic            out_v_q, out_v_d;
  signal_e         osig_q, osig_d;
  logic [31:0]     os_q, os_d, ol_q, ol_d;
  logic [6:0]      ostr_q, ostr_d;
  logic            owarm_q, owarm_d;

  logic            ram_we;
  logic [31:0]     rdata;
  logic            div_start, div_done;
  logic [DW-1:0]   div_dvd, div_quot;
  logic [SUMW-1:0] div_dsr, div_rem;

  logic [31:0]     diff, tol;
  logic            golden, death, buy_ok, sell_ok;
  signal_e         sig;

  mcrs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (q_price_i),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  mcrs_divider #(.DW(DW), .VW(SUMW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Walk far enough back for the widest of the three windows.
  assign rw_p1   = rw_i + 1'b1;
  assign n_lo    = (lw_i > rw_p1) ? lw_i : rw_p1;
  assign n_total = (sw_i > n_lo) ? sw_i : n_lo;
  assign bars_n  = (bars_q == NW'(DEPTH + 1)) ? bars_q : bars_q + 1'b1;

  // Crossover decision on the shifted and fresh averages.
  always_comb begin
    diff    = (prev_s_q > prev_l_q) ? prev_s_q - prev_l_q : prev_l_q - prev_s_q;
    tol     = {12'd0, lim_i.tolerance};
    golden  = ((prev_s_q < prev_l_q) || (diff < tol)) && (last_s_q > last_l_q);
    death   = ((prev_s_q > prev_l_q) || (diff < tol)) && (last_s_q < last_l_q);
    buy_ok  = str_q < lim_i.overbought;
    sell_ok = (str_q > lim_i.oversold) || ((str_q == lim_i.oversold) && remnz_q);
    if (warm_q)                sig = SIG_HOLD;
    else if (golden && buy_ok) sig = SIG_BUY;
    else if (death && sell_ok) sig = SIG_SELL;
    else                       sig = SIG_HOLD;
  end

  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    rd_addr_d = rd_addr_q;
    bars_d    = bars_q;
    iss_d     = iss_q;
    ridx_d    = ridx_q;
    rdv_d     = 1'b0;
    warm_d    = warm_q;
    remnz_d   = remnz_q;
    prevd_d   = prevd_q;
    ssum_d    = ssum_q;
    lsum_d    = lsum_q;
    gain_d    = gain_q;
    loss_d    = loss_q;
    last_s_d  = last_s_q;
    last_l_d  = last_l_q;
    prev_s_d  = prev_s_q;
    prev_l_d  = prev_l_q;
    str_d     = str_q;
    out_v_d   = out_v_q && out_stall_i;
    osig_d    = osig_q;
    os_d      = os_q;
    ol_d      = ol_q;
    ostr_d    = ostr_q;
    owarm_d   = owarm_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    div_dvd   = {7'd0, ssum_q};
    div_dsr   = SUMW'(sw_i);

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          ram_we    = 1'b1;
          wpos_d    = (wpos_q == AW'(DEPTH - 1)) ? '0 : wpos_q + 1'b1;
          bars_d    = bars_n;
          warm_d    = bars_n <= lw_i;
          rd_addr_d = wpos_q;
          iss_d     = '0;
          ssum_d    = '0;
          lsum_d    = '0;
          gain_d    = '0;
          loss_d    = '0;
          if (bars_n <= lw_i) begin
            state_d = ST_EMIT;
          end else begin
            prev_s_d = last_s_q;
            prev_l_d = last_l_q;
            state_d  = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Issue one ring read a cycle, walking back from the newest close.
        if (iss_q < n_total) begin
          rdv_d     = 1'b1;
          ridx_d    = iss_q;
          iss_d     = iss_q + 1'b1;
          rd_addr_d = (rd_addr_q == '0) ? AW'(DEPTH - 1) : rd_addr_q - 1'b1;
        end
        if (rdv_q) begin
          prevd_d = rdata;
          if (ridx_q < sw_i) ssum_d = ssum_q + SUMW'(rdata);
          if (ridx_q < lw_i) lsum_d = lsum_q + SUMW'(rdata);
          if ((ridx_q != '0) && (ridx_q <= rw_i)) begin
            if (prevd_q > rdata) gain_d = gain_q + SUMW'(prevd_q - rdata);
            else                 loss_d = loss_q + SUMW'(rdata - prevd_q);
          end
          if (ridx_q == n_total - 1'b1) state_d = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (bars_q < sw_i) begin
          last_s_d = '0;
          state_d  = ST_DIV_L;
        end else begin
          div_start = 1'b1;
          state_d   = ST_WAIT_S;
        end
      end
      ST_WAIT_S: begin
        if (div_done) begin
          last_s_d = div_quot[31:0];
          state_d  = ST_DIV_L;
        end
      end
      ST_DIV_L: begin
        div_start = 1'b1;
        div_dvd   = {7'd0, lsum_q};
        div_dsr   = SUMW'(lw_i);
        state_d   = ST_WAIT_L;
      end
      ST_WAIT_L: begin
        if (div_done) begin
          last_l_d = div_quot[31:0];
          state_d  = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        div_dvd = DW'(gain_q) * DW'(PERCENT_SCALE);
        div_dsr = gain_q + loss_q;
        if ((bars_q - 1'b1) < rw_i) begin
          str_d   = STRENGTH_NEUTRAL;
          remnz_d = 1'b0;
          state_d = ST_EMIT;
        end else if (loss_q == '0) begin
          str_d   = STRENGTH_FULL;
          remnz_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_WAIT_R;
        end
      end
      ST_WAIT_R: begin
        if (div_done) begin
          str_d   = div_quot[6:0];
          remnz_d = |div_rem;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          osig_d  = sig;
          os_d    = last_s_q;
          ol_d    = last_l_q;
          ostr_d  = str_q;
          owarm_d = warm_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wpos_q   <= '0;
      bars_q   <= '0;
      rdv_q    <= 1'b0;
      warm_q   <= 1'b1;
      remnz_q  <= 1'b0;
      ssum_q   <= '0;
      lsum_q   <= '0;
      gain_q   <= '0;
      loss_q   <= '0;
      last_s_q <= '0;
      last_l_q <= '0;
      prev_s_q <= '0;
      prev_l_q <= '0;
      str_q    <= STRENGTH_NEUTRAL;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wpos_q   <= wpos_d;
      bars_q   <= bars_d;
      rdv_q    <= rdv_d;
      warm_q   <= warm_d;
      remnz_q  <= remnz_d;
      ssum_q   <= ssum_d;
      lsum_q   <= lsum_d;
      gain_q   <= gain_d;
      loss_q   <= loss_d;
      last_s_q <= last_s_d;
      last_l_q <= last_l_d;
      prev_s_q <= prev_s_d;
      prev_l_q <= prev_l_d;
      str_q    <= str_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    iss_q     <= iss_d;
    ridx_q    <= ridx_d;
    prevd_q   <= prevd_d;
    osig_q    <= osig_d;
    os_q      <= os_d;
    ol_q      <= ol_d;
    ostr_q    <= ostr_d;
    owarm_q   <= owarm_d;
  end

  assign out_valid_o        = out_v_q;
  assign trade_signal_o     = osig_q;
  assign short_average_o    = os_q;
  assign long_average_o     = ol_q;
  assign strength_percent_o = ostr_q;
  assign warming_up_o       = owarm_q;
endmodule

// ===== sim/tb_ma_crossover_rsi_signal.sv =====
// Self-checking testbench for the moving-average crossover signal block.
// Depends on mcrs_pkg and the ma_crossover_rsi_signal top level; a scoreboard
// class predicts every bar result and checks the output transactions in order.
`timescale 1ns / 1ps
module tb_ma_crossover_rsi_signal;
  import mcrs_pkg::*;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    signal_e     trade;
    logic [31:0] short_avg;
    logic [31:0] long_avg;
    logic [6:0]  strength;
    logic        warm;
  } bar_result_t;

  class bar_scoreboard;
    logic [31:0]  ring [DEPTH];
    logic [7:0]   wr_pos;
    int unsigned  bars;
    logic [31:0]  last_s, last_l, prev_s, prev_l;
    logic [6:0]   last_rsi;
    int unsigned  sw_reg, lw_reg, rw_reg, tol_reg, ob_reg, os_reg;
    bar_result_t  expected_q [$];
    int unsigned  errors;

    function new();
      wr_pos = 0;
      bars = 0;
      last_s = 0;
      last_l = 0;
      prev_s = 0;
      prev_l = 0;
      last_rsi = STRENGTH_NEUTRAL;
      sw_reg = RST_SHORT_WINDOW;
      lw_reg = RST_LONG_WINDOW;
      rw_reg = RST_STRENGTH_WINDOW;
      tol_reg = RST_CROSS_TOLERANCE;
      ob_reg = RST_OVERBOUGHT;
      os_reg = RST_OVERSOLD;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] data);
      case (idx)
        CFG_SHORT_WINDOW:    sw_reg = data[8:0];
        CFG_LONG_WINDOW:     lw_reg = data[8:0];
        CFG_STRENGTH_WINDOW: rw_reg = data[7:0];
        CFG_CROSS_TOLERANCE: tol_reg = data;
        CFG_OVERBOUGHT:      ob_reg = data[6:0];
        CFG_OVERSOLD:        os_reg = data[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_len(int unsigned w, int unsigned top);
      if (w == 0) return 1;
      if (w > top) return top;
      return w;
    endfunction

    function logic [63:0] sum_back(logic [7:0] cur, int unsigned n);
      logic [63:0] s;
      logic [7:0] p;
      s = 0;
      for (int unsigned i = 0; i < n; i++) begin
        p = cur - i[7:0];
        s += ring[p];
      end
      return s;
    endfunction

    // Compute the result this bar must produce and queue it.
    function void note_bar(logic [31:0] price);
      bar_result_t r;
      logic [7:0] cur, pa, pb;
      int unsigned sw, lw, rw;
      logic [63:0] gain, loss, tot;
      logic [31:0] diff;
      logic buy_ok, sell_ok, golden, death;
      cur = wr_pos;
      sw = clamp_len(sw_reg, DEPTH);
      lw = clamp_len(lw_reg, DEPTH);
      rw = clamp_len(rw_reg, DEPTH - 1);
      ring[cur] = price;
      wr_pos = cur + 8'd1;
      if (bars < DEPTH + 1) bars++;
      r.trade = SIG_HOLD;
      r.warm = (bars <= lw);
      if (!r.warm) begin
        prev_s = last_s;
        prev_l = last_l;
        last_s = (bars < sw) ? 32'd0 : 32'(sum_back(cur, sw) / sw);
        last_l = 32'(sum_back(cur, lw) / lw);
        if (bars - 1 < rw) begin
          last_rsi = STRENGTH_NEUTRAL;
          buy_ok = 50 < ob_reg;
          sell_ok = 50 > os_reg;
        end else begin
          gain = 0;
          loss = 0;
          for (int unsigned i = 0; i < rw; i++) begin
            pa = cur - i[7:0];
            pb = pa - 8'd1;
            if (ring[pa] > ring[pb]) gain += ring[pa] - ring[pb];
            else loss += ring[pb] - ring[pa];
          end
          if (loss == 0) begin
            last_rsi = STRENGTH_FULL;
            buy_ok = 100 < ob_reg;
            sell_ok = 100 > os_reg;
          end else begin
            tot = gain + loss;
            last_rsi = 7'((64'd100 * gain) / tot);
            buy_ok = 64'd100 * gain < 64'(ob_reg) * tot;
            sell_ok = 64'd100 * gain > 64'(os_reg) * tot;
          end
        end
        diff = (prev_s > prev_l) ? prev_s - prev_l : prev_l - prev_s;
        golden = (prev_s < prev_l || diff < tol_reg) && last_s > last_l;
        death = (prev_s > prev_l || diff < tol_reg) && last_s < last_l;
        if (golden && buy_ok) r.trade = SIG_BUY;
        else if (death && sell_ok) r.trade = SIG_SELL;
      end
      r.short_avg = last_s;
      r.long_avg = last_l;
      r.strength = last_rsi;
      expected_q.push_back(r);
    endfunction

    function void check_bar(bar_result_t got);
      bar_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected: %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.trade !== exp_r.trade || got.short_avg !== exp_r.short_avg ||
          got.long_avg !== exp_r.long_avg || got.strength !== exp_r.strength ||
          got.warm !== exp_r.warm) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sig %0d/%0d short %0d/%0d long %0d/%0d rsi %0d/%0d warm %0b/%0b",
                   exp_r.trade, got.trade, exp_r.short_avg, got.short_avg,
                   exp_r.long_avg, got.long_avg, exp_r.strength, got.strength,
                   exp_r.warm, got.warm);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] close_price_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  trade_signal_o;
  logic [31:0] short_average_o;
  logic [31:0] long_average_o;
  logic [6:0]  strength_percent_o;
  logic        warming_up_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  bar_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  logic [31:0] walk_price = 32'd1000000;
  logic        walk_up = 1'b1;

  ma_crossover_rsi_signal #(.HISTORY_DEPTH(DEPTH)) u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ma_crossover_rsi_signal");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_bar({signal_e'(trade_signal_o), short_average_o, long_average_o,
                    strength_percent_o, warming_up_o});
  end

  // Receiver: randomly chosen stall mode (none, light random, periodic, heavy random); long hold-offs on request.
  initial begin
    int unsigned hold_left, mode, phase;
    hold_left = 0;
    mode = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < holds_asked) begin
        holds_done++;
        hold_left = 3000;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= (phase % 7 < 3);
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_windows(int unsigned sw, int unsigned lw, int unsigned rw,
                             int unsigned tol, int unsigned ob, int unsigned os);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_write(CFG_SHORT_WINDOW, 20'(sw));
    cfg_write(CFG_LONG_WINDOW, 20'(lw));
    cfg_write(CFG_STRENGTH_WINDOW, 20'(rw));
    cfg_write(CFG_CROSS_TOLERANCE, 20'(tol));
    cfg_write(CFG_OVERBOUGHT, 20'(ob));
    cfg_write(CFG_OVERSOLD, 20'(os));
  endtask

  // Offer one bar and hold it until the block takes it.
  task automatic send_bar(logic [31:0] price);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    close_price_i <= price;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_bar(price);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Trending walk with reversals, plus extremes and fully random noise.
  function automatic logic [31:0] next_price();
    int unsigned roll, step;
    roll = $urandom_range(0, 99);
    step = $urandom_range(0, 300000);
    if (roll < 3) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    if (roll < 8) return $urandom;
    if (roll < 18) walk_up = ~walk_up;
    if (roll < 24) return walk_price;
    if (walk_up) begin
      if (walk_price > 32'hFFFF_FFFF - step) walk_up = 1'b0;
      else walk_price += step;
    end else begin
      if (walk_price < step) walk_up = 1'b1;
      else walk_price -= step;
    end
    return walk_price;
  endfunction

  task automatic run_bars(int unsigned count, bit with_hold);
    int unsigned sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_bar(next_price());
        sent++;
        if (with_hold && sent == 30) holds_asked++;
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    idle_gap(1);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    // Directed: extremes, flat run (no losses), alternation, lift past warm-up.
    send_bar(32'd0);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'd0);
    send_bar(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_bar(32'd5000);
    for (int i = 0; i < 11; i++) send_bar(32'd5000 + 32'(i) * 32'd40000);
    for (int i = 0; i < 4; i++) send_bar(32'd400000 - 32'(i) * 32'd90000);
    idle_gap(1);
    set_windows(RST_SHORT_WINDOW, RST_LONG_WINDOW, RST_STRENGTH_WINDOW,
                RST_CROSS_TOLERANCE, RST_OVERBOUGHT, RST_OVERSOLD);
    run_bars(90, 1'b1);
    // Zero windows act as one; overbought above 100, tolerance zero.
    set_windows(0, 0, 0, 0, 127, 0);
    run_bars(50, 1'b0);
    // Short window saturates and exceeds bars seen; levels block both trades.
    set_windows(300, 3, 255, 20'hFFFFF, 0, 100);
    run_bars(40, 1'b0);
    // Longest long window, wide tolerance, oversold above 100.
    set_windows(3, 256, 200, 1000000, 100, 127);
    run_bars(170, 1'b0);
    set_windows(2, 8, 4, 50, 60, 40);
    run_bars(80, 1'b0);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS ma_crossover_rsi_signal");
    end else begin
      $display("FAIL ma_crossover_rsi_signal");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mcrs_pkg.sv
design/mcrs_ram.sv
design/mcrs_front.sv
design/mcrs_divider.sv
design/mcrs_engine.sv
design/ma_crossover_rsi_signal.sv
sim/tb_ma_crossover_rsi_signal.sv
